FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top design file. The checks drop
// out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PCG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define PCG_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PCG_ASSERT(lbl, clk, rst, prop, msg)
`define PCG_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

FILE: design/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Types and constants of the polyphonic gate/pitch to note event converter.
// ----------------------------------------------------------------------------
package pcg_pkg;

   // field widths
   localparam int LANE_CNT_W = 5;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_RESET  = 1'b1;

   // event kinds
   localparam logic [1:0] EVT_NOTE_OFF = 2'd0;
   localparam logic [1:0] EVT_NOTE_ON  = 2'd1;
   localparam logic [1:0] EVT_PITCH    = 2'd2;

   // register indexes
   localparam logic [1:0] REG_GATE_HIGH = 2'd0;
   localparam logic [1:0] REG_GATE_LOW  = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;

   // register reset values
   localparam logic [16:0] GATE_HIGH_RST = 17'd4096;
   localparam logic [16:0] GATE_LOW_RST  = 17'd409;
   localparam logic [15:0] THRESHOLD_RST = 16'd41;

   // arithmetic constants
   localparam logic [21:0] NOTE_BASE   = 22'd245760;  // 60 semitones, 1/4096 units
   localparam logic [21:0] ROUND_HALF  = 22'd2048;
   localparam logic [6:0]  NOTE_MAX    = 7'd127;
   localparam logic [12:0] VEL_DEFAULT = 13'd3277;    // 0.8 in Q12
   localparam logic [12:0] VEL_FULL    = 13'd4096;
   localparam logic [16:0] VEL_ROUND   = 17'd5;
   localparam logic [15:0] VEL_RECIP   = 16'd52429;   // 2^19 / 10, rounded up
   localparam int          VEL_SHIFT   = 19;

   typedef struct packed {
      logic signed [16:0] gate_high;
      logic signed [16:0] gate_low;
      logic [15:0]        threshold;
   } pcg_cfg_type;

   typedef struct packed {
      logic               kind;
      logic [3:0]         lane;
      logic [4:0]         lane_count;
      logic signed [16:0] gate_level;
      logic signed [16:0] pitch_level;
      logic signed [4:0]  octave;
      logic signed [16:0] velocity_level;
      logic               velocity_present;
      logic [15:0]        frame_offset;
   } pcg_item_type;

   typedef struct packed {
      logic               gate_high;
      logic               active;
      logic [6:0]         note;
      logic signed [21:0] offset;
   } pcg_lane_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  lane;
      logic [6:0]  note;
      logic [12:0] velocity;
      logic [21:0] offset;
      logic [15:0] time_stamp;
      logic        last;
   } pcg_event_type;

   typedef struct packed {
      logic               rising;
      logic               falling;
      logic               send_pitch;
      logic [6:0]         note;
      logic [12:0]        velocity;
      logic signed [21:0] new_offset;
      logic signed [21:0] held_offset;
   } pcg_calc_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_one;
      logic clr_all;
   } pcg_mem_cmd_type;

endpackage

FILE: design/poly_cv_gate_to_note_events.sv
// ----------------------------------------------------------------------------
// poly_cv_gate_to_note_events
// Turns per-lane gate, pitch and velocity levels into note-on, note-off and
// pitch offset events, with lane count changes and a reset-all item.
// ----------------------------------------------------------------------------
// One item is handled at a time. A lane sample steps through accept, decode,
// memory read, update and write, and last-event flush before the next ready;
// a lane 0 sample adds a lane count check, and a rise adds a step for its
// second event. A lane 0 item that lowers the lane count also walks the
// dropped lanes through the lane record memory (read, then check and clear);
// a reset item walks every lane in use with a read and a check, then clears
// all records at once. The read-then-update on the lane record memory sets
// these steps; an event that cannot move on because the result channel is
// stalled holds the sequencer. There is no clearing pass after reset.

`include "assert_macros.svh"

module poly_cv_gate_to_note_events import pcg_pkg::*; #(
   parameter int MAX_LANES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // lane, lane_count, gate_level, pitch_level, octave, velocity_level,
   // velocity_present, frame_offset
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,   // kind
   // result events
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // event_lane, note_number, velocity, pitch_offset, event_time
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // event_kind
   output logic                  rsp_tlast,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam logic [LANE_CNT_W-1:0] LANE_MAX = LANE_CNT_W'(MAX_LANES);
   localparam logic [LANE_CNT_W-1:0] LANE_ONE = LANE_CNT_W'(1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_WRD   = 3'd2;
   localparam logic [2:0] S_WCHK  = 3'd3;
   localparam logic [2:0] S_LRD   = 3'd4;
   localparam logic [2:0] S_LCHK  = 3'd5;
   localparam logic [2:0] S_PITCH = 3'd6;
   localparam logic [2:0] S_FLUSH = 3'd7;

   logic [2:0]            state_ff, state_in;
   pcg_item_type          item_ff, item_in;
   logic [LANE_CNT_W-1:0] lanes_ff, lanes_in;
   logic [LANE_CNT_W-1:0] walk_idx_ff, walk_idx_in;
   logic [LANE_CNT_W-1:0] walk_end_ff, walk_end_in;
   logic [LANE_CNT_W-1:0] req_count;

   pcg_cfg_type           cfg;
   pcg_calc_type          calc;
   pcg_mem_cmd_type       mem_cmd;
   logic [LANE_W-1:0]     rd_addr;
   logic [LANE_W-1:0]     wr_addr;
   pcg_lane_type          wr_data;
   pcg_lane_type          rd_data;
   logic                  evt_push;
   logic                  evt_flush;
   logic                  evt_ready;
   logic                  evt_pend;
   pcg_event_type         evt;
   logic                  req_beat;

   pcg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pcg_lane_mem #(
      .DEPTH  (MAX_LANES),
      .ADDR_W (LANE_W)
   ) u_lane_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   pcg_note_calc u_note_calc (
      .item (item_ff),
      .rec  (rd_data),
      .cfg  (cfg),
      .calc (calc)
   );

   pcg_event_out u_event_out (
      .clock      (clock),
      .reset      (reset),
      .push       (evt_push),
      .flush      (evt_flush),
      .evt        (evt),
      .ready      (evt_ready),
      .pend       (evt_pend),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;

   // requested lane count, clamped to 1..MAX_LANES
   always_comb begin
      if (item_ff.lane_count == '0) begin
         req_count = LANE_ONE;
      end else if (item_ff.lane_count > LANE_MAX) begin
         req_count = LANE_MAX;
      end else begin
         req_count = item_ff.lane_count;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      lanes_in    = lanes_ff;
      walk_idx_in = walk_idx_ff;
      walk_end_in = walk_end_ff;
      mem_cmd     = '0;
      rd_addr     = walk_idx_ff[LANE_W-1:0];
      wr_addr     = walk_idx_ff[LANE_W-1:0];
      wr_data     = rd_data;
      evt_push    = 1'b0;
      evt_flush   = 1'b0;
      evt.kind       = EVT_NOTE_OFF;
      evt.lane       = item_ff.lane;
      evt.note       = rd_data.note;
      evt.velocity   = '0;
      evt.offset     = '0;
      evt.time_stamp = item_ff.frame_offset;
      evt.last       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               item_in.kind             = req_tuser[0];
               item_in.lane             = req_tdata[3:0];
               item_in.lane_count       = req_tdata[8:4];
               item_in.gate_level       = req_tdata[25:9];
               item_in.pitch_level      = req_tdata[42:26];
               item_in.octave           = req_tdata[47:43];
               item_in.velocity_level   = req_tdata[64:48];
               item_in.velocity_present = req_tdata[65];
               item_in.frame_offset     = req_tdata[81:66];
               state_in = S_START;
            end
         end

         // pick the lane walk, if any
         S_START: begin
            if (item_ff.kind == KIND_RESET) begin
               walk_idx_in = '0;
               walk_end_in = lanes_ff;
               state_in    = S_WRD;
            end else if (item_ff.lane == '0) begin
               walk_idx_in = req_count;
               walk_end_in = lanes_ff;
               lanes_in    = req_count;
               state_in    = S_WRD;
            end else begin
               state_in = S_LRD;
            end
         end

         // walk: read the next lane or finish
         S_WRD: begin
            if (walk_idx_ff >= walk_end_ff) begin
               if (item_ff.kind == KIND_RESET) begin
                  mem_cmd.clr_all = 1'b1;
                  lanes_in        = LANE_ONE;
                  state_in        = S_FLUSH;
               end else begin
                  state_in = S_LRD;
               end
            end else begin
               mem_cmd.rd_en = 1'b1;
               state_in      = S_WCHK;
            end
         end

         // walk: note-off for an active lane, clear on count drop
         S_WCHK: begin
            evt.lane = walk_idx_ff[3:0];
            evt_push = rd_data.active;
            if (!rd_data.active || evt_ready) begin
               mem_cmd.clr_one = (item_ff.kind == KIND_SAMPLE);
               walk_idx_in     = walk_idx_ff + LANE_ONE;
               state_in        = S_WRD;
            end
         end

         // sampled lane: read its record if in use
         S_LRD: begin
            rd_addr = item_ff.lane[LANE_W-1:0];
            if ({1'b0, item_ff.lane} < lanes_ff) begin
               mem_cmd.rd_en = 1'b1;
               state_in      = S_LCHK;
            end else begin
               state_in = S_FLUSH;
            end
         end

         // sampled lane: update record and send events
         S_LCHK: begin
            wr_addr = item_ff.lane[LANE_W-1:0];
            if (calc.rising) begin
               evt_push     = 1'b1;
               evt.kind     = EVT_NOTE_ON;
               evt.note     = calc.note;
               evt.velocity = calc.velocity;
               if (evt_ready) begin
                  mem_cmd.wr_en     = 1'b1;
                  wr_data.gate_high = 1'b1;
                  wr_data.active    = 1'b1;
                  wr_data.note      = calc.note;
                  wr_data.offset    = calc.new_offset;
                  state_in          = S_PITCH;
               end
            end else if (calc.falling) begin
               evt_push = rd_data.active;
               if (!rd_data.active || evt_ready) begin
                  mem_cmd.wr_en     = 1'b1;
                  wr_data.gate_high = 1'b0;
                  wr_data.active    = 1'b0;
                  state_in          = S_FLUSH;
               end
            end else if (rd_data.active && calc.send_pitch) begin
               evt_push   = 1'b1;
               evt.kind   = EVT_PITCH;
               evt.offset = calc.held_offset;
               if (evt_ready) begin
                  mem_cmd.wr_en  = 1'b1;
                  wr_data.offset = calc.held_offset;
                  state_in       = S_FLUSH;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end

         // second event of a rise
         S_PITCH: begin
            evt_push   = 1'b1;
            evt.kind   = EVT_PITCH;
            evt.note   = calc.note;
            evt.offset = calc.new_offset;
            if (evt_ready) begin
               state_in = S_FLUSH;
            end
         end

         // release the held event as the last of the item
         S_FLUSH: begin
            evt_flush = 1'b1;
            if (evt_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         lanes_ff    <= LANE_ONE;
         walk_idx_ff <= '0;
         walk_end_ff <= '0;
      end else begin
         state_ff    <= state_in;
         lanes_ff    <= lanes_in;
         walk_idx_ff <= walk_idx_in;
         walk_end_ff <= walk_end_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // lane count always inside the supported range
   `PCG_ASSERT_NEVER(a_lanes_range, clock, reset, (lanes_ff == '0) || (lanes_ff > LANE_MAX), "lane count out of range")
   // walk index never runs past the lane array
   `PCG_ASSERT_NEVER(a_walk_bound, clock, reset, walk_idx_ff > LANE_MAX, "lane walk past last lane")
   // every event of an item has left the holding stage before the next item
   `PCG_ASSERT(a_idle_flushed, clock, reset, (state_ff == S_IDLE) |-> !evt_pend, "event held while idle")

endmodule

FILE: design/pcg_csr.sv
// ----------------------------------------------------------------------------
// pcg_csr
// Register file behind the configuration port: gate thresholds and pitch
// change threshold.
// ----------------------------------------------------------------------------
module pcg_csr import pcg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output pcg_cfg_type           cfg
);

   pcg_cfg_type cfg_ff;
   pcg_cfg_type cfg_in;
   logic        wr_beat;

   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (csr_paddr[3:2])
            REG_GATE_HIGH: cfg_in.gate_high = csr_pwdata[16:0];
            REG_GATE_LOW:  cfg_in.gate_low  = csr_pwdata[16:0];
            REG_THRESHOLD: cfg_in.threshold = csr_pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_high <= GATE_HIGH_RST;
         cfg_ff.gate_low  <= GATE_LOW_RST;
         cfg_ff.threshold <= THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, levels sign extended
   always_comb begin
      case (csr_paddr[3:2])
         REG_GATE_HIGH: csr_prdata = {{15{cfg_ff.gate_high[16]}}, cfg_ff.gate_high};
         REG_GATE_LOW:  csr_prdata = {{15{cfg_ff.gate_low[16]}}, cfg_ff.gate_low};
         REG_THRESHOLD: csr_prdata = {16'd0, cfg_ff.threshold};
         default:       csr_prdata = '0;
      endcase
   end

endmodule

FILE: design/pcg_lane_mem.sv
// ----------------------------------------------------------------------------
// pcg_lane_mem
// Lane record memory: one write port, one registered read port, and a valid
// bit per lane so that a cleared or never written lane reads as all zero.
// ----------------------------------------------------------------------------
module pcg_lane_mem import pcg_pkg::*; #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  pcg_mem_cmd_type   cmd,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pcg_lane_type      wr_data,
   output pcg_lane_type      rd_data
);

   pcg_lane_type     mem_ff [DEPTH];
   pcg_lane_type     rdq_ff;
   logic             hit_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   // valid bits: set on write, dropped on clear
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clr_all) begin
         valid_in = '0;
      end else if (cmd.clr_one) begin
         valid_in[wr_addr] = 1'b0;
      end else if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   // storage array
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdq_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? rdq_ff : '0;

endmodule

FILE: design/pcg_note_calc.sv
// ----------------------------------------------------------------------------
// pcg_note_calc
// Per-sample arithmetic: absolute pitch, note rounding and clamping, pitch
// offsets, gate hysteresis and note-on velocity.
// ----------------------------------------------------------------------------
module pcg_note_calc import pcg_pkg::*; (
   input  pcg_item_type item,
   input  pcg_lane_type rec,
   input  pcg_cfg_type  cfg,
   output pcg_calc_type calc
);

   logic signed [21:0] pitch_ext;
   logic signed [9:0]  oct_ext;
   logic signed [9:0]  oct12;
   logic signed [21:0] abs_pitch;
   logic [21:0]        round_sum;
   logic [6:0]         note;
   logic signed [23:0] delta;
   logic [23:0]        delta_mag;
   logic [16:0]        vel_sum;
   logic [32:0]        vel_prod;
   logic [13:0]        vel_quot;

   // absolute pitch: 60 + 12*V + 12*octave semitones
   assign pitch_ext = {{5{item.pitch_level[16]}}, item.pitch_level};
   assign oct_ext   = {{5{item.octave[4]}}, item.octave};
   assign oct12     = (oct_ext <<< 3) + (oct_ext <<< 2);
   assign abs_pitch = $signed(NOTE_BASE) + (pitch_ext <<< 3) + (pitch_ext <<< 2)
                      + $signed({oct12, 12'd0});

   // round half away from zero, negatives clamp to note zero
   assign round_sum = abs_pitch + ROUND_HALF;
   always_comb begin
      if (abs_pitch[21]) begin
         note = 7'd0;
      end else if (round_sum[21:12] > {3'd0, NOTE_MAX}) begin
         note = NOTE_MAX;
      end else begin
         note = round_sum[18:12];
      end
   end

   // offsets against the new and the latched note
   assign calc.note        = note;
   assign calc.new_offset  = abs_pitch - $signed({3'd0, note, 12'd0});
   assign calc.held_offset = abs_pitch - $signed({3'd0, rec.note, 12'd0});

   // change of the held offset against the last one sent
   assign delta      = {{2{calc.held_offset[21]}}, calc.held_offset}
                       - {{2{rec.offset[21]}}, rec.offset};
   assign delta_mag  = delta[23] ? 24'(-delta) : 24'(delta);
   assign calc.send_pitch = delta_mag >= {8'd0, cfg.threshold};

   // gate hysteresis
   assign calc.rising  = !rec.gate_high && ($signed(item.gate_level) >= cfg.gate_high);
   assign calc.falling = rec.gate_high && ($signed(item.gate_level) <= cfg.gate_low);

   // velocity = level / 10 rounded, by reciprocal multiply
   assign vel_sum  = {1'b0, item.velocity_level[15:0]} + VEL_ROUND;
   assign vel_prod = 33'(vel_sum) * 33'(VEL_RECIP);
   assign vel_quot = vel_prod[32:VEL_SHIFT];

   always_comb begin
      if (!item.velocity_present) begin
         calc.velocity = VEL_DEFAULT;
      end else if (item.velocity_level[16] || (item.velocity_level == '0)) begin
         calc.velocity = 13'd0;
      end else if (vel_quot > {1'b0, VEL_FULL}) begin
         calc.velocity = VEL_FULL;
      end else begin
         calc.velocity = vel_quot[12:0];
      end
   end

endmodule

FILE: design/pcg_event_out.sv
// ----------------------------------------------------------------------------
// pcg_event_out
// Event output: a holding stage keeps the newest event until the next one or
// the end of the item shows whether it is the last, then an output register
// drives the result channel.
// ----------------------------------------------------------------------------
module pcg_event_out import pcg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  flush,
   input  pcg_event_type         evt,
   output logic                  ready,
   output logic                  pend,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // lane, note, velocity, offset, time
   output logic [1:0]            rsp_tuser,   // event kind
   output logic                  rsp_tlast
);

   pcg_event_type pend_ff;
   pcg_event_type pend_in;
   logic          pend_valid_ff;
   logic          pend_valid_in;
   pcg_event_type out_ff;
   pcg_event_type out_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic          out_free;

   assign out_free = !out_valid_ff || rsp_tready;
   assign ready    = !pend_valid_ff || out_free;
   assign pend     = pend_valid_ff;

   // move held event to output when a newer one arrives or the item ends
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (push && ready) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_in.last  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = evt;
         pend_valid_in = 1'b1;
      end else if (flush && pend_valid_ff && out_free) begin
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   // beat packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {2'd0, out_ff.time_stamp, out_ff.offset, out_ff.velocity,
                        out_ff.note, out_ff.lane};

endmodule

FILE: sim/poly_cv_gate_to_note_events_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_cv_gate_to_note_events_test
// Self-checking bench for the lane gate/pitch to note event converter. A
// scoreboard class keeps its own lane table and thresholds, works out the
// note-on, note-off and pitch beats that each accepted item should cause, and
// compares them in order with the result stream. Directed items cover the
// field extremes and the lane count and reset-all walks; random frames then
// run under several threshold settings with random stalls on both sides.
// ----------------------------------------------------------------------------

module poly_cv_gate_to_note_events_test;
   import pcg_pkg::*;

   localparam int NUM_LANES   = 16;
   localparam int SETTLE      = 64;      // margin for lane walks to finish
   localparam int CYCLE_LIMIT = 800000;
   localparam int PHASE_ITEMS = 26;
   localparam int NUM_PHASES  = 5;

   // -------------------------------------------------------------------------
   // expected note events
   // -------------------------------------------------------------------------
   class note_event_board;
      int             gate_high_lvl;
      int             gate_low_lvl;
      int             pitch_step;
      bit             gate_up[NUM_LANES];
      bit             sounding[NUM_LANES];
      logic [6:0]     note_of[NUM_LANES];
      int             offset_of[NUM_LANES];
      int             lanes_used;
      pcg_event_type  batch[$];
      pcg_event_type  pending[$];
      int             errors;

      function new();
         gate_high_lvl = $signed(GATE_HIGH_RST);
         gate_low_lvl  = $signed(GATE_LOW_RST);
         pitch_step    = THRESHOLD_RST;
         for (int i = 0; i < NUM_LANES; i++) clear_lane(i);
         lanes_used = 1;
         errors     = 0;
      endfunction

      function void clear_lane(int i);
         gate_up[i]   = 1'b0;
         sounding[i]  = 1'b0;
         note_of[i]   = '0;
         offset_of[i] = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_GATE_HIGH: gate_high_lvl = $signed(value[16:0]);
            REG_GATE_LOW:  gate_low_lvl  = $signed(value[16:0]);
            REG_THRESHOLD: pitch_step    = value[15:0];
            default: ;
         endcase
      endfunction

      function void add(logic [1:0] kind, int ln, logic [6:0] note, int vel, int off,
                        logic [15:0] stamp);
         pcg_event_type ev;
         ev.kind       = kind;
         ev.lane       = 4'(ln);
         ev.note       = note;
         ev.velocity   = 13'(vel);
         ev.offset     = 22'(off);
         ev.time_stamp = stamp;
         ev.last       = 1'b0;
         batch.push_back(ev);
      endfunction

      // work out the events of one accepted item and queue them
      function int note_item(pcg_item_type it);
         int ln, req, g, p, oct, vl, a, r, vel, held, d, ad;
         logic [15:0] stamp;
         batch.delete();
         stamp = it.frame_offset;
         if (it.kind == KIND_RESET) begin
            for (int i = 0; i < lanes_used; i++)
               if (sounding[i]) add(EVT_NOTE_OFF, i, note_of[i], 0, 0, stamp);
            for (int i = 0; i < NUM_LANES; i++) clear_lane(i);
            lanes_used = 1;
         end else begin
            ln = it.lane;
            // lane 0 carries the lane count; dropped lanes are silenced
            if (ln == 0) begin
               req = it.lane_count;
               if (req < 1) req = 1;
               if (req > NUM_LANES) req = NUM_LANES;
               for (int i = req; i < lanes_used; i++) begin
                  if (sounding[i]) add(EVT_NOTE_OFF, i, note_of[i], 0, 0, stamp);
                  clear_lane(i);
               end
               lanes_used = req;
            end
            if (ln < lanes_used) begin
               g   = $signed(it.gate_level);
               p   = $signed(it.pitch_level);
               oct = $signed(it.octave);
               vl  = $signed(it.velocity_level);
               a   = int'(NOTE_BASE) + 12 * p + 12 * 4096 * oct;
               // nearest semitone, half away from zero, then clamp
               if (a >= 0) r = (a + 2048) >>> 12;
               else r = -((-a + 2048) >>> 12);
               if (r < 0) r = 0;
               if (r > 127) r = 127;
               if (!gate_up[ln] && g >= gate_high_lvl) begin
                  gate_up[ln]   = 1'b1;
                  sounding[ln]  = 1'b1;
                  note_of[ln]   = 7'(r);
                  offset_of[ln] = a - r * 4096;
                  if (!it.velocity_present) vel = VEL_DEFAULT;
                  else if (vl <= 0) vel = 0;
                  else begin
                     vel = (vl + 5) / 10;
                     if (vel > 4096) vel = 4096;
                  end
                  add(EVT_NOTE_ON, ln, note_of[ln], vel, 0, stamp);
                  add(EVT_PITCH, ln, note_of[ln], 0, offset_of[ln], stamp);
               end else if (gate_up[ln] && g <= gate_low_lvl) begin
                  gate_up[ln] = 1'b0;
                  if (sounding[ln]) begin
                     add(EVT_NOTE_OFF, ln, note_of[ln], 0, 0, stamp);
                     sounding[ln] = 1'b0;
                  end
               end else if (sounding[ln]) begin
                  // held note: resend the offset once it has moved enough
                  held = a - int'(note_of[ln]) * 4096;
                  d    = held - offset_of[ln];
                  ad   = d < 0 ? -d : d;
                  if (ad >= pitch_step) begin
                     offset_of[ln] = held;
                     add(EVT_PITCH, ln, note_of[ln], 0, held, stamp);
                  end
               end
            end
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) pending.push_back(batch[i]);
         return batch.size();
      endfunction

      // compare one result beat with the oldest expected event
      function void check_event(pcg_event_type got);
         pcg_event_type exp_ev;
         if (pending.size() == 0) begin
            $error("unexpected event beat: kind %0d lane %0d", got.kind, got.lane);
            errors++;
            return;
         end
         exp_ev = pending.pop_front();
         if (got.kind != exp_ev.kind) begin
            $error("event_kind: expected %0d, got %0d", exp_ev.kind, got.kind);
            errors++;
         end
         if (got.lane != exp_ev.lane) begin
            $error("event_lane: expected %0d, got %0d", exp_ev.lane, got.lane);
            errors++;
         end
         if (got.note != exp_ev.note) begin
            $error("note_number: expected %0d, got %0d", exp_ev.note, got.note);
            errors++;
         end
         if (got.velocity != exp_ev.velocity) begin
            $error("velocity: expected %0d, got %0d", exp_ev.velocity, got.velocity);
            errors++;
         end
         if (got.offset != exp_ev.offset) begin
            $error("pitch_offset: expected %0d, got %0d",
                   $signed(exp_ev.offset), $signed(got.offset));
            errors++;
         end
         if (got.time_stamp != exp_ev.time_stamp) begin
            $error("event_time: expected %0d, got %0d", exp_ev.time_stamp, got.time_stamp);
            errors++;
         end
         if (got.last != exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, got.last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and block under test
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   note_event_board board = new();
   int              cycle_count = 0;

   // random frame state per lane
   bit stim_on[NUM_LANES];
   int stim_pitch[NUM_LANES];
   int stim_oct[NUM_LANES];

   poly_cv_gate_to_note_events u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // idle lengths: mostly none or short, now and then long
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10) return 0;
      if (pick < 16) return $urandom_range(1, 3);
      if (pick < 19) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int clamp17(int v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic pcg_item_type make_item(logic kind, int ln, int cnt, int gate,
                                              int pitch, int oct, int vlevel, bit vpres,
                                              logic [15:0] stamp);
      pcg_item_type it;
      it.kind             = kind;
      it.lane             = 4'(ln);
      it.lane_count       = 5'(cnt);
      it.gate_level       = 17'(gate);
      it.pitch_level      = 17'(pitch);
      it.octave           = 5'(oct);
      it.velocity_level   = 17'(vlevel);
      it.velocity_present = vpres;
      it.frame_offset     = stamp;
      return it;
   endfunction

   // one lane of a well-formed frame: gates toggle now and then, pitch drifts
   function automatic pcg_item_type lane_sample(int ln, int cnt, logic [15:0] stamp);
      int g, vl;
      if ($urandom_range(0, 3) == 0) begin
         stim_on[ln] = !stim_on[ln];
         if (stim_on[ln]) begin
            stim_pitch[ln] = $urandom_range(0, 16384) - 8192;
            if ($urandom_range(0, 3) == 0) stim_oct[ln] = $urandom_range(0, 31) - 16;
            else stim_oct[ln] = $urandom_range(0, 2) - 1;
         end
      end else if ($urandom_range(0, 7) == 0) begin
         stim_pitch[ln] = clamp17(stim_pitch[ln] + $urandom_range(0, 1000) - 500);
      end else begin
         stim_pitch[ln] = clamp17(stim_pitch[ln] + $urandom_range(0, 20) - 10);
      end
      if (stim_on[ln]) g = board.gate_high_lvl + $urandom_range(0, 3000);
      else g = board.gate_low_lvl - $urandom_range(0, 3000);
      if ($urandom_range(0, 3) == 0) vl = $urandom_range(0, 131071);
      else vl = $urandom_range(0, 45000);
      return make_item(KIND_SAMPLE, ln, cnt, clamp17(g), stim_pitch[ln], stim_oct[ln], vl,
                       $urandom_range(0, 3) != 0, stamp);
   endfunction

   // -------------------------------------------------------------------------
   // input beats, driven at the falling edge
   // -------------------------------------------------------------------------
   task automatic send_item(input pcg_item_type it);
      int gap;
      req_tuser  = it.kind;
      req_tdata  = {6'b0, it.frame_offset, it.velocity_present, it.velocity_level,
                    it.octave, it.pitch_level, it.gate_level, it.lane_count, it.lane};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      void'(board.note_item(it));
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // register write followed by a read-back
   task automatic write_reg(input logic [1:0] idx, input int value, input int width);
      logic [31:0] mask;
      mask        = (32'd1 << width) - 1;
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if ((csr_prdata & mask) != (value & mask)) begin
         $error("register %0d read-back: expected %0h, got %0h", idx, value & mask,
                csr_prdata & mask);
         board.errors++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // result side: random stalls, beats checked at the rising edge
   // -------------------------------------------------------------------------
   initial begin
      int run, stall, pick;
      rsp_tready = 1'b0;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
         rsp_tready = 1'b1;
         repeat (run) @(negedge clock);
         pick = $urandom_range(0, 9);
         if (pick < 7) stall = $urandom_range(0, 3);
         else if (pick < 9) stall = $urandom_range(4, 12);
         else stall = $urandom_range(20, 40);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      pcg_event_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind       = rsp_tuser;
         got.lane       = rsp_tdata[3:0];
         got.note       = rsp_tdata[10:4];
         got.velocity   = rsp_tdata[23:11];
         got.offset     = rsp_tdata[45:24];
         got.time_stamp = rsp_tdata[61:46];
         got.last       = rsp_tlast;
         board.check_event(got);
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   int cfg_high[NUM_PHASES] = '{4096, 40960, -40960, 2048, 0};
   int cfg_low[NUM_PHASES]  = '{409, -40960, 40960, 1024, 0};
   int cfg_step[NUM_PHASES] = '{41, 65535, 0, 200, 1};

   initial begin
      pcg_item_type it;
      logic [95:0]  raw;
      logic [15:0]  stamp;
      int           sent, pick, cnt, eff, frame_cnt;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         stim_on[i]    = 1'b0;
         stim_pitch[i] = 0;
         stim_oct[i]   = 0;
      end
      frame_cnt = 4;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // registers change only once the block has gone quiet
         if (ph > 0) begin
            req_tvalid = 1'b0;
            while (board.pending.size() != 0) @(posedge clock);
            repeat (SETTLE) @(posedge clock);
            @(negedge clock);
         end
         write_reg(REG_GATE_HIGH, cfg_high[ph], 17);
         write_reg(REG_GATE_LOW, cfg_low[ph], 17);
         write_reg(REG_THRESHOLD, cfg_step[ph], 16);

         if (ph == 0) begin
            // lane above the count is ignored
            send_item(make_item(KIND_SAMPLE, 3, 1, 8000, 0, 0, 1000, 1, 16'h0001));
            // rise exactly at the high level, velocity saturates
            send_item(make_item(KIND_SAMPLE, 0, 4, 4096, 0, 0, 40960, 1, 16'h0002));
            // top pitch clamps to 127, default velocity
            send_item(make_item(KIND_SAMPLE, 1, 31, 65535, 65535, 15, 0, 0, 16'hFFFF));
            // bottom pitch clamps to 0, negative velocity
            send_item(make_item(KIND_SAMPLE, 2, 0, 5000, -65536, -16, -5, 1, 16'h8000));
            // exact half semitone rounds up, velocity 15 rounds to 2
            send_item(make_item(KIND_SAMPLE, 3, 0, 5000, 512, -5, 15, 1, 16'h0004));
            // held offset just under, then past, the threshold
            send_item(make_item(KIND_SAMPLE, 0, 4, 2000, 3, 0, 0, 1, 16'h0005));
            send_item(make_item(KIND_SAMPLE, 0, 4, 2000, 4, 0, 0, 1, 16'h0006));
            send_item(make_item(KIND_SAMPLE, 0, 4, 2000, 0, 0, 0, 1, 16'h0007));
            // fall exactly at the low level, then a further low gate
            send_item(make_item(KIND_SAMPLE, 1, 4, 409, 0, 0, 0, 1, 16'h0008));
            send_item(make_item(KIND_SAMPLE, 1, 4, -65536, 0, 0, 0, 1, 16'h0009));
            // velocity 14 rounds to 1
            send_item(make_item(KIND_SAMPLE, 1, 4, 4500, 0, 0, 14, 1, 16'h000A));
            send_item(make_item(KIND_SAMPLE, 2, 4, 409, 0, 0, 0, 1, 16'h000B));
            send_item(make_item(KIND_SAMPLE, 3, 4, 5000, -512, -5, 0, 1, 16'h000C));
            // count 0 means one lane: the upper lanes go silent
            send_item(make_item(KIND_SAMPLE, 0, 0, 2000, 0, 0, 0, 1, 16'h000D));
            send_item(make_item(KIND_SAMPLE, 2, 4, 8000, 0, 0, 0, 1, 16'h000E));
            // count above the lane total is cut to 16
            send_item(make_item(KIND_SAMPLE, 0, 31, 2000, 0, 0, 0, 1, 16'h000F));
            // negative half semitone clamps to note zero
            send_item(make_item(KIND_SAMPLE, 5, 0, 4096, -512, -5, 200, 0, 16'h0010));
            send_item(make_item(KIND_SAMPLE, 15, 0, 65535, 1000, 1, 65535, 1, 16'h0011));
            // reset-all with notes sounding, then with none
            send_item(make_item(KIND_RESET, 15, 31, 65535, 65535, 15, 65535, 1, 16'h0012));
            send_item(make_item(KIND_RESET, 0, 0, 0, 0, 0, 0, 0, 16'h0013));
            // shrinking the count from 16 to 2 silences lanes in order
            send_item(make_item(KIND_SAMPLE, 0, 16, 4096, 1000, 2, 30000, 1, 16'h0014));
            send_item(make_item(KIND_SAMPLE, 7, 0, 5000, 0, 0, 500, 1, 16'h0015));
            send_item(make_item(KIND_SAMPLE, 9, 0, 5000, 0, 0, 500, 1, 16'h0016));
            send_item(make_item(KIND_SAMPLE, 0, 2, 2000, 1000, 2, 0, 1, 16'h0017));
            send_item(make_item(KIND_SAMPLE, 0, 2, -65536, 1000, 2, 0, 1, 16'h0018));
            for (int i = 0; i < NUM_LANES; i++) stim_on[i] = 1'b0;
         end

         // random frames, with reset-all items and raw noise mixed in
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               raw = {$urandom, $urandom, $urandom};
               it  = raw[$bits(pcg_item_type)-1:0];
               it.kind = KIND_RESET;
               send_item(it);
               for (int i = 0; i < NUM_LANES; i++) stim_on[i] = 1'b0;
               frame_cnt = 1;
               sent++;
            end else if (pick < 12) begin
               raw = {$urandom, $urandom, $urandom};
               it  = raw[$bits(pcg_item_type)-1:0];
               it.kind = KIND_SAMPLE;
               send_item(it);
            end else begin
               if (pick < 22) begin
                  case ($urandom_range(0, 9))
                     0:       frame_cnt = $urandom_range(0, 31);
                     1, 2:    frame_cnt = 16;
                     default: frame_cnt = $urandom_range(1, 6);
                  endcase
               end
               cnt = frame_cnt;
               eff = cnt < 1 ? 1 : (cnt > NUM_LANES ? NUM_LANES : cnt);
               for (int i = eff; i < NUM_LANES; i++) stim_on[i] = 1'b0;
               stamp = $urandom_range(0, 65535);
               for (int ln = 0; ln < eff; ln++) begin
                  send_item(lane_sample(ln, cnt, stamp));
                  sent++;
               end
            end
         end
      end

      req_tvalid = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
